>>> design/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSL package
// Shared widths, payload structs and the job record passed from the front
// end to the divider pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int CHANNEL_BITS    = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int HUE_W = CHANNEL_BITS + 3;
  localparam int SAT_W = CHANNEL_BITS + 1;
  localparam int NUM_W = 2 * CHANNEL_BITS + 1;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
    logic [CHANNEL_BITS-1:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] hue_out;
    logic [CHANNEL_BITS-1:0] saturation_out;
    logic [CHANNEL_BITS-1:0] lightness_out;
    logic [CHANNEL_BITS-1:0] alpha_out;
  } pixel_out_t;

  typedef struct packed {
    logic [HUE_W-1:0]        hue_num;
    logic [HUE_W-1:0]        hue_div;
    logic [NUM_W-1:0]        sat_num;
    logic [SAT_W-1:0]        sat_div;
    logic                    grey;
    logic [CHANNEL_BITS-1:0] lightness;
    logic [CHANNEL_BITS-1:0] alpha;
  } job_t;

endpackage

>>> design/rgbhsl_front.sv
// ----------------------------------------------------------------------------
// RGB to HSL front end
// Finds max, min and spread of a pixel, picks the hue sector and forms the
// numerators and divisors for the divider pipeline.
// ----------------------------------------------------------------------------
module rgbhsl_front (
  input  rgbhsl_pkg::pixel_in_t pixel,
  output rgbhsl_pkg::job_t      job
);
  import rgbhsl_pkg::*;

  localparam int CW = CHANNEL_BITS;

  logic [CW-1:0]    r, g, b, mx, mn, d;
  logic [CW:0]      sum;
  logic [CW+1:0]    sum_round;
  logic [HUE_W-1:0] dx, hnum;
  logic [SAT_W-1:0] sdiv;
  logic [SAT_W-1:0] full2;

  always_comb begin
    r = pixel.red_in;
    g = pixel.green_in;
    b = pixel.blue_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    sum_round = {1'b0, sum} + {{(CW+1){1'b0}}, 1'b1};
    dx = {3'b000, d};
    if (mx == r) begin
      hnum = (g >= b) ? ({3'b000, g} - {3'b000, b})
                      : ((dx << 2) + (dx << 1) - {3'b000, b} + {3'b000, g});
    end else if (mx == g) begin
      hnum = (dx << 1) + {3'b000, b} - {3'b000, r};
    end else begin
      hnum = (dx << 2) + {3'b000, r} - {3'b000, g};
    end
    full2 = {{CW{1'b1}}, 1'b0};
    sdiv = (sum > {1'b0, {CW{1'b1}}}) ? (full2 - sum) : sum;
    job.hue_num   = hnum;
    job.hue_div   = (dx << 2) + (dx << 1);
    job.sat_div   = sdiv;
    job.sat_num   = ({1'b0, d, {CW{1'b0}}} - {{(CW+1){1'b0}}, d})
                    + {{CW{1'b0}}, 1'b0, sdiv[SAT_W-1:1]};
    job.grey      = (d == '0);
    job.lightness = sum_round[CW:1];
    job.alpha     = pixel.alpha_in;
  end

endmodule

>>> design/rgbhsl_queue.sv
// ----------------------------------------------------------------------------
// RGB to HSL job queue
// Small first-in first-out buffer between the front end and the divider
// pipeline so that each side can stall on its own.
// ----------------------------------------------------------------------------
module rgbhsl_queue #(
  parameter int DEPTH = rgbhsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rgbhsl_pkg::job_t push_job,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output rgbhsl_pkg::job_t head
);
  import rgbhsl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [CNTW-1:0] count;

  assign not_full  = (count != CNTW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH)) else $error("queue count above depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && count == '0)) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && count == CNTW'(DEPTH))) else $error("push into full queue");

endmodule

>>> design/rgbhsl_back.sv
// ----------------------------------------------------------------------------
// RGB to HSL back end
// Pipelined restoring dividers, one quotient bit per stage for hue and
// saturation, followed by hue rounding and the output register.
// ----------------------------------------------------------------------------
module rgbhsl_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  input  rgbhsl_pkg::job_t       job,
  output logic                   job_take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rgbhsl_pkg::pixel_out_t out_data
);
  import rgbhsl_pkg::*;

  localparam int CW = CHANNEL_BITS;

  logic             adv;
  logic             valid [CW+1];
  job_t             sjob  [CW+1];
  logic [HUE_W-1:0] hrem  [CW+1];
  logic [SAT_W-1:0] srem  [CW+1];
  logic [CW-1:0]    hq    [CW+1];
  logic [CW-1:0]    sq    [CW+1];
  logic [CW-1:0]    hue_rounded;

  assign adv      = !out_valid || out_ready;
  assign job_take = adv && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv) begin
      valid[0] <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sjob[0] <= job;
      hrem[0] <= (job.hue_num >= job.hue_div) ? job.hue_num - job.hue_div : job.hue_num;
      srem[0] <= job.sat_num[NUM_W-1:CW];
      hq[0]   <= '0;
      sq[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= CW; k++) begin : g_stage
    logic [HUE_W:0] ht;
    logic [SAT_W:0] st;
    logic           hbit, sbit;

    always_comb begin
      ht   = {hrem[k-1], 1'b0};
      st   = {srem[k-1], sjob[k-1].sat_num[CW-k]};
      hbit = (ht >= {1'b0, sjob[k-1].hue_div});
      sbit = (st >= {1'b0, sjob[k-1].sat_div});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (adv) begin
        valid[k] <= valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sjob[k] <= sjob[k-1];
        hrem[k] <= hbit ? HUE_W'(ht - {1'b0, sjob[k-1].hue_div}) : HUE_W'(ht);
        srem[k] <= sbit ? SAT_W'(st - {1'b0, sjob[k-1].sat_div}) : SAT_W'(st);
        hq[k]   <= {hq[k-1][CW-2:0], hbit};
        sq[k]   <= {sq[k-1][CW-2:0], sbit};
      end
    end
  end

  assign hue_rounded = hq[CW] + CW'(hrem[CW] >= {1'b0, sjob[CW].hue_div[HUE_W-1:1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= valid[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.hue_out        <= sjob[CW].grey ? '0 : hue_rounded;
      out_data.saturation_out <= sjob[CW].grey ? '0 : sq[CW];
      out_data.lightness_out  <= sjob[CW].lightness;
      out_data.alpha_out      <= sjob[CW].alpha;
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(valid[CW]) && $stable(valid[0]))
    else $error("pipeline moved while output stalled");
  a_take_adv: assert property (@(posedge clk) disable iff (rst)
    job_take |-> adv) else $error("job taken while pipeline stalled");
  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    (adv && valid[CW] && sjob[CW].grey) |=> out_data.saturation_out == '0)
    else $error("grey pixel with nonzero saturation");

endmodule

>>> design/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter
//
//   channel   direction  signals                       word
//   input     in         in_valid, in_ready, in_data   pixel_in_t (RGBA)
//   output    out        out_valid, out_ready, out_data pixel_out_t (HSLA)
//
// One pixel is accepted per clock while the queue is not full; each pixel then
// passes the queue, the divider pipeline of one bit per stage and output register.
// A queue of QUEUE_DEPTH jobs separates the front end from the dividers.
// Synchronous reset clears the queue and all valid flags.
// An output stall freezes the whole divider pipeline; input keeps flowing
// until the queue fills.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter #(
  parameter int QUEUE_DEPTH = rgbhsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rgbhsl_pkg::pixel_in_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rgbhsl_pkg::pixel_out_t out_data
);
  import rgbhsl_pkg::*;

  job_t new_job, head_job;
  logic head_valid, take;

  rgbhsl_front u_front (
    .pixel (in_data),
    .job   (new_job)
  );

  rgbhsl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_job  (new_job),
    .not_full  (in_ready),
    .pop       (take),
    .not_empty (head_valid),
    .head      (head_job)
  );

  rgbhsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_take  (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
